>>> design/nbpc_pkg.sv
package nbpc_pkg;

   localparam int KIND_WIDTH = 3;
   localparam int FREQ_WIDTH = 3;
   localparam int BIDX_WIDTH = 9;
   localparam int VAL_WIDTH = 16;
   localparam int VERDICT_WIDTH = 2;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH = 24;
   localparam int SCALE_WIDTH = 24;
   localparam int BCOUNT_WIDTH = 9;
   localparam int ABS_WIDTH = VAL_WIDTH + 1;
   localparam int PROD_WIDTH = ABS_WIDTH + SCALE_WIDTH;
   localparam int SCALE_SHIFT = 22;
   localparam int QUOT_WIDTH = PROD_WIDTH - SCALE_SHIFT;

   localparam logic [KIND_WIDTH-1:0] KIND_CLEAR = 3'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_LOAD = 3'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_SIDE = 3'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_POINT = 3'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_BOX = 3'd4;

   localparam logic [VERDICT_WIDTH-1:0] VERDICT_FEASIBLE = 2'd0;
   localparam logic [VERDICT_WIDTH-1:0] VERDICT_INFEASIBLE = 2'd1;
   localparam logic [VERDICT_WIDTH-1:0] VERDICT_AMBIGUOUS = 2'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BUCKET_COUNT = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PHASE_SCALE = 1'd1;

   localparam logic [BCOUNT_WIDTH-1:0] BUCKET_COUNT_RESET = 9'd360;
   localparam logic [SCALE_WIDTH-1:0] PHASE_SCALE_RESET = 24'd65536;

endpackage

>>> design/nbpc_req_if.sv
interface nbpc_req_if;
   import nbpc_pkg::*;
   logic                         valid;
   logic                         ready;
   logic [KIND_WIDTH-1:0]        kind;
   logic [FREQ_WIDTH-1:0]        frequency_index;
   logic [BIDX_WIDTH-1:0]        bucket_index;
   logic signed [VAL_WIDTH-1:0]  phase;
   logic signed [VAL_WIDTH-1:0]  magnitude;
   logic signed [VAL_WIDTH-1:0]  phase_high;
   logic signed [VAL_WIDTH-1:0]  magnitude_high;
   logic                         allowed_above;

   modport source (output valid, kind, frequency_index, bucket_index, phase, magnitude,
                   phase_high, magnitude_high, allowed_above, input ready);
   modport sink (input valid, kind, frequency_index, bucket_index, phase, magnitude,
                 phase_high, magnitude_high, allowed_above, output ready);
endinterface

>>> design/nbpc_rsp_if.sv
interface nbpc_rsp_if;
   import nbpc_pkg::*;
   logic                         valid;
   logic                         ready;
   logic [VERDICT_WIDTH-1:0]     verdict;
   logic                         bottom_left_forbidden;
   logic                         top_right_forbidden;
   logic signed [VAL_WIDTH-1:0]  min_magnitude_bound;
   logic signed [VAL_WIDTH-1:0]  max_magnitude_bound;
   logic signed [VAL_WIDTH-1:0]  min_phase_bound;
   logic signed [VAL_WIDTH-1:0]  max_phase_bound;
   logic                         bound_found;
   logic                         status;

   modport source (output valid, verdict, bottom_left_forbidden, top_right_forbidden,
                   min_magnitude_bound, max_magnitude_bound, min_phase_bound,
                   max_phase_bound, bound_found, status, input ready);
   modport sink (input valid, verdict, bottom_left_forbidden, top_right_forbidden,
                 min_magnitude_bound, max_magnitude_bound, min_phase_bound,
                 max_phase_bound, bound_found, status, output ready);
endinterface

>>> design/nbpc_csr_if.sv
interface nbpc_csr_if;
   import nbpc_pkg::*;
   logic                        valid;
   logic                        ready;
   logic [CSR_INDEX_WIDTH-1:0]  index;
   logic [CSR_DATA_WIDTH-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> design/nbpc_ram.sv
module nbpc_ram #(
   parameter int ADDR_WIDTH = 12,
   parameter int DATA_WIDTH = 3
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);
   logic [DATA_WIDTH-1:0] mem [2**ADDR_WIDTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> design/nichols_boundary_parity_classifier.sv
// Channel  Dir  Beat contents
// -------  ---  ---------------------------------------------------------------
// req      in   kind, frequency_index, bucket_index, phase/magnitude, high corner, side
// rsp      out  verdict, corner flags, span extremes, bound_found, status
// csr      in   index (0 bucket_count, 1 phase_scale), data; always ready
//
// Steps: clear zeroes every fill entry of its frequency, load reads the fill and then writes
// the fill and point, set side is taken at dispatch. Classify point scans its bucket's slots;
// classify box adds a scan of every bucket in the span on the fill and point memory read
// ports, and a second corner scan.
// Reset: a clearing pass writes zero to every fill entry, 2^(freq bits + bucket bits) of
// them (4096 at the defaults), with req held not ready; csr writes are taken.
// Stalls: a new beat is taken while a result waits on rsp; it is held in its final
// step until the earlier result has been taken.
module nichols_boundary_parity_classifier #(
   parameter int FREQUENCIES = 8,
   parameter int BUCKETS = 512,
   parameter int SLOTS = 4
) (
   input  logic clock,
   input  logic reset,
   nbpc_req_if.sink   req,
   nbpc_rsp_if.source rsp,
   nbpc_csr_if.sink   csr
);
   import nbpc_pkg::*;

   localparam int FW = (FREQUENCIES > 1) ? $clog2(FREQUENCIES) : 1;
   localparam int BW = $clog2(BUCKETS);
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int FAW = FW + BW;
   localparam int PAW = FW + BW + SW;

   localparam logic [3:0] S_INIT = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_DISPATCH = 4'd2;
   localparam logic [3:0] S_CLR = 4'd3;
   localparam logic [3:0] S_LD_RD = 4'd4;
   localparam logic [3:0] S_LD_WR = 4'd5;
   localparam logic [3:0] S_BK0 = 4'd6;
   localparam logic [3:0] S_BK1 = 4'd7;
   localparam logic [3:0] S_BK2 = 4'd8;
   localparam logic [3:0] S_SC_START = 4'd9;
   localparam logic [3:0] S_SC_FILL = 4'd10;
   localparam logic [3:0] S_SC_N = 4'd11;
   localparam logic [3:0] S_SC_SLOT = 4'd12;
   localparam logic [3:0] S_SC_NEXT = 4'd13;
   localparam logic [3:0] S_FIN = 4'd14;

   localparam logic [1:0] SEL_BOX = 2'd0;
   localparam logic [1:0] SEL_BL = 2'd1;
   localparam logic [1:0] SEL_TR = 2'd2;

   // configuration registers
   logic [BCOUNT_WIDTH-1:0] bucket_count_ff;
   logic [SCALE_WIDTH-1:0]  phase_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= BUCKET_COUNT_RESET;
         phase_scale_ff <= PHASE_SCALE_RESET;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_BUCKET_COUNT: bucket_count_ff <= csr.data[BCOUNT_WIDTH-1:0];
            CSR_PHASE_SCALE:  phase_scale_ff <= csr.data[SCALE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign csr.ready = 1'b1;

   // sequencer state and item registers
   logic [3:0]                 state_ff, state_in;
   logic [KIND_WIDTH-1:0]      kind_ff;
   logic [FREQ_WIDTH-1:0]      freq_ff;
   logic [BIDX_WIDTH-1:0]      bidx_ff;
   logic signed [VAL_WIDTH-1:0] ph_ff, mag_ff, phh_ff, magh_ff;
   logic                       allow_ff;

   logic [FREQUENCIES-1:0]     side_ff;
   logic [FAW-1:0]             init_cnt_ff;
   logic [BW-1:0]              clr_cnt_ff;
   logic [PROD_WIDTH-1:0]      prod_ff;
   logic [BW-1:0]              b0_ff, b1_ff, cur_b_ff, hi_b_ff;
   logic [1:0]                 sel_ff;
   logic [CW-1:0]              n_ff;
   logic [SW-1:0]              slot_ff;
   logic                       pend_ff;
   logic                       below_ff;
   logic                       found_ff, amb_ff, bl_ff, tr_ff, st_ff;
   logic signed [VAL_WIDTH-1:0] mnm_ff, mxm_ff, mnp_ff, mxp_ff;

   // memory ports
   logic                  fill_we;
   logic [FAW-1:0]        fill_waddr, fill_raddr;
   logic [CW-1:0]         fill_wdata, fill_rdata;
   logic                  pt_we;
   logic [PAW-1:0]        pt_waddr, pt_raddr;
   logic [2*VAL_WIDTH-1:0] pt_wdata, pt_rdata;

   nbpc_ram #(.ADDR_WIDTH(FAW), .DATA_WIDTH(CW)) u_fill (
      .clock(clock), .wr_en(fill_we), .wr_addr(fill_waddr), .wr_data(fill_wdata),
      .rd_addr(fill_raddr), .rd_data(fill_rdata)
   );

   nbpc_ram #(.ADDR_WIDTH(PAW), .DATA_WIDTH(2*VAL_WIDTH)) u_point (
      .clock(clock), .wr_en(pt_we), .wr_addr(pt_waddr), .wr_data(pt_wdata),
      .rd_addr(pt_raddr), .rd_data(pt_rdata)
   );

   logic [FW-1:0] f_addr;
   logic [BW-1:0] ld_b;
   logic          freq_ok;
   logic          rsp_free;
   assign f_addr = FW'(freq_ff);
   assign ld_b = BW'(bidx_ff);
   assign freq_ok = 32'(freq_ff) < FREQUENCIES;
   assign rsp_free = !rsp.valid || rsp.ready;

   // bucket of a phase: |p| * scale, then shift and clamp
   logic signed [VAL_WIDTH-1:0] mul_src;
   logic [ABS_WIDTH-1:0]        mul_abs;
   logic [PROD_WIDTH-1:0]       prod_in;
   logic [QUOT_WIDTH-1:0]       quot, lim, clamped;
   logic [BW-1:0]               bucket_v;

   always_comb begin
      mul_src = (state_ff == S_BK0) ? ph_ff : phh_ff;
      mul_abs = mul_src[VAL_WIDTH-1] ? (ABS_WIDTH'(0) - {mul_src[VAL_WIDTH-1], mul_src})
                                     : {1'b0, mul_src};
      prod_in = PROD_WIDTH'(mul_abs) * PROD_WIDTH'(phase_scale_ff);
      quot = prod_ff[PROD_WIDTH-1:SCALE_SHIFT];
      lim = (QUOT_WIDTH'(bucket_count_ff) < QUOT_WIDTH'(BUCKETS - 1))
          ? QUOT_WIDTH'(bucket_count_ff) : QUOT_WIDTH'(BUCKETS - 1);
      clamped = (quot > lim) ? lim : quot;
      bucket_v = BW'(clamped);
   end

   // stored point under inspection, in the cycle after its read
   logic signed [VAL_WIDTH-1:0] sp, sm, cmp_mag;
   logic in_span, below_hit, below_nx, forbid_nx;

   always_comb begin
      sp = pt_rdata[2*VAL_WIDTH-1:VAL_WIDTH];
      sm = pt_rdata[VAL_WIDTH-1:0];
      cmp_mag = (sel_ff == SEL_TR) ? magh_ff : mag_ff;
      in_span = (sp >= ph_ff) && (sp <= phh_ff);
      below_hit = pend_ff && (cmp_mag > sm);
      below_nx = below_ff ^ below_hit;
      // even count of lower points: under the union
      forbid_nx = below_nx ? !side_ff[f_addr] : side_ff[f_addr];
   end

   // memory access selection
   always_comb begin
      fill_we = 1'b0;
      fill_waddr = {f_addr, ld_b};
      fill_wdata = CW'(0);
      fill_raddr = {f_addr, cur_b_ff};
      pt_we = 1'b0;
      pt_waddr = {f_addr, ld_b, SW'(fill_rdata)};
      pt_wdata = {ph_ff, mag_ff};
      pt_raddr = {f_addr, cur_b_ff, slot_ff};
      case (state_ff)
         S_INIT: begin
            fill_we = 1'b1;
            fill_waddr = init_cnt_ff;
         end
         S_CLR: begin
            fill_we = 1'b1;
            fill_waddr = {f_addr, clr_cnt_ff};
         end
         S_LD_RD: begin
            fill_raddr = {f_addr, ld_b};
         end
         S_LD_WR: begin
            if (32'(fill_rdata) < SLOTS) begin
               fill_we = 1'b1;
               fill_wdata = fill_rdata + CW'(1);
               pt_we = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT:     if (&init_cnt_ff) state_in = S_IDLE;
         S_IDLE:     if (req.valid) state_in = S_DISPATCH;
         S_DISPATCH: begin
            if (!freq_ok) begin
               state_in = S_FIN;
            end else begin
               case (kind_ff)
                  KIND_CLEAR: state_in = S_CLR;
                  KIND_LOAD:  state_in = (32'(bidx_ff) < BUCKETS) ? S_LD_RD : S_FIN;
                  KIND_POINT: state_in = S_BK0;
                  KIND_BOX:   state_in = S_BK0;
                  default:    state_in = S_FIN;
               endcase
            end
         end
         S_CLR:      if (clr_cnt_ff == BW'(BUCKETS - 1)) state_in = S_FIN;
         S_LD_RD:    state_in = S_LD_WR;
         S_LD_WR:    state_in = S_FIN;
         S_BK0:      state_in = S_BK1;
         S_BK1:      state_in = S_BK2;
         S_BK2:      state_in = S_SC_START;
         S_SC_START: state_in = S_SC_FILL;
         S_SC_FILL:  state_in = S_SC_N;
         S_SC_N:     state_in = (fill_rdata == CW'(0)) ? S_SC_NEXT : S_SC_SLOT;
         S_SC_SLOT:  if ((CW'(slot_ff) + CW'(1)) == n_ff) state_in = S_SC_NEXT;
         S_SC_NEXT: begin
            if (cur_b_ff != hi_b_ff) begin
               state_in = S_SC_FILL;
            end else if (sel_ff == SEL_BOX) begin
               state_in = S_SC_START;
            end else if (sel_ff == SEL_BL && kind_ff == KIND_BOX) begin
               state_in = S_SC_START;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN:      if (rsp_free) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   assign req.ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         init_cnt_ff <= FAW'(0);
         side_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff <= (state_ff == S_SC_SLOT);
         if (state_ff == S_INIT) begin
            init_cnt_ff <= init_cnt_ff + FAW'(1);
         end
         if (state_ff == S_DISPATCH && freq_ok && kind_ff == KIND_SIDE) begin
            side_ff[f_addr] <= allow_ff;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         kind_ff <= req.kind;
         freq_ff <= req.frequency_index;
         bidx_ff <= req.bucket_index;
         ph_ff <= req.phase;
         mag_ff <= req.magnitude;
         phh_ff <= req.phase_high;
         magh_ff <= req.magnitude_high;
         allow_ff <= req.allowed_above;
      end
      prod_ff <= prod_in;
      case (state_ff)
         S_DISPATCH: begin
            clr_cnt_ff <= BW'(0);
            found_ff <= 1'b0;
            amb_ff <= 1'b0;
            bl_ff <= 1'b0;
            tr_ff <= 1'b0;
            mnm_ff <= '0;
            mxm_ff <= '0;
            mnp_ff <= '0;
            mxp_ff <= '0;
            // out-of-range load bucket is rejected here
            st_ff <= freq_ok && kind_ff == KIND_LOAD && !(32'(bidx_ff) < BUCKETS);
         end
         S_CLR: clr_cnt_ff <= clr_cnt_ff + BW'(1);
         S_LD_WR: begin
            if (!(32'(fill_rdata) < SLOTS)) st_ff <= 1'b1;
         end
         S_BK1: b0_ff <= bucket_v;
         S_BK2: begin
            b1_ff <= bucket_v;
            sel_ff <= (kind_ff == KIND_BOX) ? SEL_BOX : SEL_BL;
         end
         S_SC_START: begin
            below_ff <= 1'b0;
            case (sel_ff)
               SEL_BOX: begin
                  cur_b_ff <= (b0_ff < b1_ff) ? b0_ff : b1_ff;
                  hi_b_ff <= (b0_ff < b1_ff) ? b1_ff : b0_ff;
               end
               SEL_BL: begin
                  cur_b_ff <= b0_ff;
                  hi_b_ff <= b0_ff;
               end
               default: begin
                  cur_b_ff <= b1_ff;
                  hi_b_ff <= b1_ff;
               end
            endcase
         end
         S_SC_N: begin
            n_ff <= fill_rdata;
            slot_ff <= SW'(0);
         end
         S_SC_SLOT: slot_ff <= slot_ff + SW'(1);
         S_SC_NEXT: begin
            if (cur_b_ff != hi_b_ff) begin
               cur_b_ff <= cur_b_ff + BW'(1);
            end else if (sel_ff == SEL_BOX) begin
               sel_ff <= SEL_BL;
            end else if (sel_ff == SEL_BL) begin
               bl_ff <= forbid_nx;
               sel_ff <= SEL_TR;
            end else begin
               tr_ff <= forbid_nx;
            end
         end
         default: ;
      endcase

      // fold in the point read in the previous cycle
      if (pend_ff) begin
         if (sel_ff == SEL_BOX) begin
            if (in_span) begin
               found_ff <= 1'b1;
               if (!found_ff || sm < mnm_ff) mnm_ff <= sm;
               if (!found_ff || sm > mxm_ff) mxm_ff <= sm;
               if (!found_ff || sp < mnp_ff) mnp_ff <= sp;
               if (!found_ff || sp > mxp_ff) mxp_ff <= sp;
               if (sm >= mag_ff && sm <= magh_ff) amb_ff <= 1'b1;
            end
         end else begin
            below_ff <= below_nx;
         end
      end
   end

   // result register: holds a beat until taken
   logic is_box;
   assign is_box = freq_ok && kind_ff == KIND_BOX;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp.valid <= 1'b0;
      end else if (state_ff == S_FIN && rsp_free) begin
         rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
         rsp.valid <= 1'b0;
      end
      if (state_ff == S_FIN && rsp_free) begin
         rsp.verdict <= (is_box && amb_ff) ? VERDICT_AMBIGUOUS
                      : (bl_ff ? VERDICT_INFEASIBLE : VERDICT_FEASIBLE);
         rsp.bottom_left_forbidden <= is_box && bl_ff;
         rsp.top_right_forbidden <= tr_ff;
         rsp.min_magnitude_bound <= mnm_ff;
         rsp.max_magnitude_bound <= mxm_ff;
         rsp.min_phase_bound <= mnp_ff;
         rsp.max_phase_bound <= mxp_ff;
         rsp.bound_found <= found_ff;
         rsp.status <= st_ff;
      end
   end
endmodule

>>> tb/nbpc_checker.sv
module nbpc_checker #(
   parameter int FREQUENCIES = 8,
   parameter int BUCKETS = 512,
   parameter int SLOTS = 4
) (
   input  logic clock,
   input  logic reset,
   nbpc_req_if  req,
   nbpc_rsp_if  rsp,
   nbpc_csr_if  csr,
   output int   errors,
   output int   pending,
   output int   beats,
   output int   box_count,
   output int   ambiguous_count,
   output int   rejected_count
);
   import nbpc_pkg::*;

   typedef struct {
      logic [VERDICT_WIDTH-1:0] verdict;
      logic                     bl_forbidden;
      logic                     tr_forbidden;
      logic signed [15:0]       min_mag;
      logic signed [15:0]       max_mag;
      logic signed [15:0]       min_ph;
      logic signed [15:0]       max_ph;
      logic                     found;
      logic                     status;
   } verdict_type;

   verdict_type verdict_q[$];

   logic signed [15:0] pt_phase [FREQUENCIES][BUCKETS][SLOTS];
   logic signed [15:0] pt_mag   [FREQUENCIES][BUCKETS][SLOTS];
   int                 fill     [FREQUENCIES][BUCKETS];
   logic               side_up  [FREQUENCIES];
   logic [BCOUNT_WIDTH-1:0] top_bucket;
   logic [SCALE_WIDTH-1:0]  scale;

   initial begin
      foreach (fill[f, b]) fill[f][b] = 0;
      foreach (side_up[f]) side_up[f] = 1'b0;
      top_bucket = BUCKET_COUNT_RESET;
      scale = PHASE_SCALE_RESET;
      errors = 0;
      pending = 0;
      beats = 0;
      box_count = 0;
      ambiguous_count = 0;
      rejected_count = 0;
   end

   function automatic int span_bucket(logic signed [15:0] p);
      longint mag_abs;
      longint b;
      mag_abs = (p < 0) ? -longint'(p) : longint'(p);
      b = (mag_abs * longint'(scale)) >>> SCALE_SHIFT;
      if (b > top_bucket) b = top_bucket;
      if (b > BUCKETS - 1) b = BUCKETS - 1;
      return int'(b);
   endfunction

   // odd count below the point means the point sits over the union
   function automatic logic forbidden(int f, logic signed [15:0] p, logic signed [15:0] m);
      int b;
      int below;
      b = span_bucket(p);
      below = 0;
      for (int s = 0; s < fill[f][b] && s < SLOTS; s++)
         if (m > pt_mag[f][b][s]) below++;
      return (below % 2 == 0) ? side_up[f] : !side_up[f];
   endfunction

   function automatic verdict_type classify(logic [2:0] kind, int f, int bi,
                                            logic signed [15:0] ph, logic signed [15:0] mg,
                                            logic signed [15:0] phh, logic signed [15:0] mgh,
                                            logic above);
      verdict_type v;
      int lo, hi, n;
      logic amb;
      logic signed [15:0] p, m;
      v = '{default: '0};
      if (f >= FREQUENCIES) return v;
      case (kind)
         KIND_CLEAR: begin
            for (int b = 0; b < BUCKETS; b++) fill[f][b] = 0;
         end
         KIND_LOAD: begin
            if (bi >= BUCKETS || fill[f][bi] >= SLOTS) begin
               v.status = 1'b1;
            end else begin
               pt_phase[f][bi][fill[f][bi]] = ph;
               pt_mag[f][bi][fill[f][bi]] = mg;
               fill[f][bi]++;
            end
         end
         KIND_SIDE: side_up[f] = above;
         KIND_POINT: v.verdict = forbidden(f, ph, mg) ? VERDICT_INFEASIBLE : VERDICT_FEASIBLE;
         KIND_BOX: begin
            lo = span_bucket(ph);
            hi = span_bucket(phh);
            if (lo > hi) begin
               n = lo;
               lo = hi;
               hi = n;
            end
            amb = 1'b0;
            for (int b = lo; b <= hi; b++) begin
               for (int s = 0; s < fill[f][b] && s < SLOTS; s++) begin
                  p = pt_phase[f][b][s];
                  m = pt_mag[f][b][s];
                  if (p >= ph && p <= phh) begin
                     if (!v.found) begin
                        v.min_mag = m;
                        v.max_mag = m;
                        v.min_ph = p;
                        v.max_ph = p;
                        v.found = 1'b1;
                     end else begin
                        if (m < v.min_mag) v.min_mag = m;
                        if (m > v.max_mag) v.max_mag = m;
                        if (p < v.min_ph) v.min_ph = p;
                        if (p > v.max_ph) v.max_ph = p;
                     end
                     if (m >= mg && m <= mgh) amb = 1'b1;
                  end
               end
            end
            v.bl_forbidden = forbidden(f, ph, mg);
            v.tr_forbidden = forbidden(f, phh, mgh);
            v.verdict = amb ? VERDICT_AMBIGUOUS :
                        (v.bl_forbidden ? VERDICT_INFEASIBLE : VERDICT_FEASIBLE);
         end
         default: ;
      endcase
      return v;
   endfunction

   task automatic report(string field, int got, int want);
      errors++;
      $display("mismatch on %s: got %0d, expected %0d (t=%0t)", field, got, want, $time);
   endtask

   verdict_type want_v;

   // Sample mid-cycle: whatever is valid and ready here is taken at the next rising edge.
   always @(negedge clock) begin
      if (!reset) begin
         if (csr.valid && csr.ready) begin
            if (csr.index == CSR_BUCKET_COUNT) top_bucket = csr.data[BCOUNT_WIDTH-1:0];
            else if (csr.index == CSR_PHASE_SCALE) scale = csr.data[SCALE_WIDTH-1:0];
         end
         if (rsp.valid && rsp.ready) begin
            beats++;
            if (verdict_q.size() == 0) begin
               report("unexpected result beat", 1, 0);
            end else begin
               want_v = verdict_q.pop_front();
               if (rsp.verdict != want_v.verdict)
                  report("verdict", rsp.verdict, want_v.verdict);
               if (rsp.bottom_left_forbidden != want_v.bl_forbidden)
                  report("bottom_left_forbidden", rsp.bottom_left_forbidden, want_v.bl_forbidden);
               if (rsp.top_right_forbidden != want_v.tr_forbidden)
                  report("top_right_forbidden", rsp.top_right_forbidden, want_v.tr_forbidden);
               if (rsp.min_magnitude_bound != want_v.min_mag)
                  report("min_magnitude_bound", rsp.min_magnitude_bound, want_v.min_mag);
               if (rsp.max_magnitude_bound != want_v.max_mag)
                  report("max_magnitude_bound", rsp.max_magnitude_bound, want_v.max_mag);
               if (rsp.min_phase_bound != want_v.min_ph)
                  report("min_phase_bound", rsp.min_phase_bound, want_v.min_ph);
               if (rsp.max_phase_bound != want_v.max_ph)
                  report("max_phase_bound", rsp.max_phase_bound, want_v.max_ph);
               if (rsp.bound_found != want_v.found)
                  report("bound_found", rsp.bound_found, want_v.found);
               if (rsp.status != want_v.status)
                  report("status", rsp.status, want_v.status);
            end
         end
         if (req.valid && req.ready) begin
            beats++;
            want_v = classify(req.kind, int'(req.frequency_index), int'(req.bucket_index),
                              req.phase, req.magnitude, req.phase_high, req.magnitude_high,
                              req.allowed_above);
            if (req.kind == KIND_BOX) box_count++;
            if (want_v.verdict == VERDICT_AMBIGUOUS) ambiguous_count++;
            if (want_v.status) rejected_count++;
            verdict_q.push_back(want_v);
         end
         pending = verdict_q.size();
      end
   end

endmodule

>>> tb/tb_top.sv
module tb_top;
   import nbpc_pkg::*;

   localparam int WATCHDOG_LIMIT = 30000;
   localparam int ITEMS_PER_PHASE = 140;

   logic clock;
   logic reset;

   nbpc_req_if req ();
   nbpc_rsp_if rsp ();
   nbpc_csr_if csr ();

   int errors, pending, beats, box_count, ambiguous_count, rejected_count;
   logic quiet;       // last part of the run: no idling on either side
   logic hold_rsp;    // ask the receiver for one long hold-off
   logic [BCOUNT_WIDTH-1:0] aim_top;
   logic [SCALE_WIDTH-1:0]  aim_scale;

   typedef struct {
      logic [KIND_WIDTH-1:0] kind;
      logic [FREQ_WIDTH-1:0] freq;
      logic [BIDX_WIDTH-1:0] bucket;
      logic signed [15:0]    ph;
      logic signed [15:0]    mg;
      logic signed [15:0]    phh;
      logic signed [15:0]    mgh;
      logic                  above;
   } req_beat_type;

   nichols_boundary_parity_classifier DUT (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp),
      .csr(csr)
   );

   nbpc_checker u_checker (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp),
      .csr(csr),
      .errors(errors),
      .pending(pending),
      .beats(beats),
      .box_count(box_count),
      .ambiguous_count(ambiguous_count),
      .rejected_count(rejected_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: random ready bursts, one long hold-off on request, always ready at the end.
   initial begin
      rsp.ready = 1'b0;
      forever begin
         if (hold_rsp) begin
            rsp.ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (quiet || $urandom_range(0, 2) != 0) begin
            rsp.ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   initial begin
      int idle_cycles;
      int last_beats;
      idle_cycles = 0;
      last_beats = 0;
      forever begin
         @(posedge clock);
         if (beats != last_beats) idle_cycles = 0;
         else idle_cycles++;
         last_beats = beats;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Bucket that a point of phase p falls into under the current settings.
   function automatic logic [BIDX_WIDTH-1:0] aim_bucket(logic signed [15:0] p);
      longint b;
      b = (((p < 0) ? -longint'(p) : longint'(p)) * longint'(aim_scale)) >>> SCALE_SHIFT;
      if (b > aim_top) b = aim_top;
      return b[BIDX_WIDTH-1:0];
   endfunction

   function automatic logic signed [15:0] rand_phase();
      if ($urandom_range(0, 19) == 0) return 16'($urandom_range(0, 65535));
      return 16'(-$signed(17'($urandom_range(0, 23040))));
   endfunction

   function automatic logic signed [15:0] rand_mag();
      if ($urandom_range(0, 9) < 3) return 16'($urandom_range(0, 65535));
      return 16'($signed(17'($urandom_range(0, 2000))) - 17'sd1000);
   endfunction

   function automatic req_beat_type rand_beat();
      req_beat_type t;
      int pick;
      logic signed [15:0] sw;
      t.kind = KIND_POINT;
      t.freq = 3'($urandom_range(0, 7));
      t.bucket = 9'($urandom_range(0, 511));
      t.ph = rand_phase();
      t.mg = rand_mag();
      t.phh = rand_phase();
      t.mgh = rand_mag();
      t.above = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         t.kind = KIND_LOAD;
         if ($urandom_range(0, 9) != 0) t.bucket = aim_bucket(t.ph);
      end else if (pick < 38) begin
         t.kind = KIND_SIDE;
      end else if (pick < 60) begin
         t.kind = KIND_POINT;
      end else if (pick < 95) begin
         // keep most boxes narrow so the bucket scan stays short
         t.kind = KIND_BOX;
         t.ph = 16'(-$signed(17'($urandom_range(0, 23040))));
         t.phh = 16'(t.ph + $signed(17'($urandom_range(0, 1280))));
         if (t.phh > 0) t.phh = 0;
         t.mgh = 16'(t.mg + $signed(17'($urandom_range(0, 1500))));
         if (t.mgh < t.mg) t.mgh = 16'sh7fff;
         if ($urandom_range(0, 9) == 0) begin
            sw = t.ph;
            t.ph = t.phh;
            t.phh = sw;
         end
      end else if (pick < 97) begin
         t.kind = KIND_CLEAR;
      end else begin
         t.kind = 3'($urandom_range(0, 7));
         t.ph = 16'($urandom_range(0, 65535));
         t.phh = 16'(t.ph + $signed(17'($urandom_range(0, 640))));
      end
      return t;
   endfunction

   task automatic send(req_beat_type t);
      logic hit;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.kind <= t.kind;
      req.frequency_index <= t.freq;
      req.bucket_index <= t.bucket;
      req.phase <= t.ph;
      req.magnitude <= t.mg;
      req.phase_high <= t.phh;
      req.magnitude_high <= t.mgh;
      req.allowed_above <= t.above;
      // ready is settled mid-cycle; sample it there to avoid edge races
      do begin
         @(negedge clock);
         hit = req.ready;
         @(posedge clock);
      end while (!hit);
   endtask

   task automatic send_fields(logic [2:0] k, int f, int b, int p, int m, int ph_hi, int m_hi,
                              logic a);
      req_beat_type t;
      t = '{k, f[2:0], b[8:0], p[15:0], m[15:0], ph_hi[15:0], m_hi[15:0], a};
      send(t);
   endtask

   task automatic csr_write(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] val);
      logic hit;
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= val;
      do begin
         @(negedge clock);
         hit = csr.ready;
         @(posedge clock);
      end while (!hit);
      csr.valid <= 1'b0;
      @(posedge clock);
      if (idx == CSR_BUCKET_COUNT) aim_top = val[BCOUNT_WIDTH-1:0];
      else aim_scale = val[SCALE_WIDTH-1:0];
   endtask

   // Drop valid and wait for the block to drain before touching settings.
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      int phase_no;
      quiet = 1'b0;
      hold_rsp = 1'b0;
      aim_top = BUCKET_COUNT_RESET;
      aim_scale = PHASE_SCALE_RESET;
      reset = 1'b1;
      req.valid = 1'b0;
      req.kind = KIND_CLEAR;
      req.frequency_index = '0;
      req.bucket_index = '0;
      req.phase = '0;
      req.magnitude = '0;
      req.phase_high = '0;
      req.magnitude_high = '0;
      req.allowed_above = 1'b0;
      csr.valid = 1'b0;
      csr.index = CSR_BUCKET_COUNT;
      csr.data = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: defaults, full bucket, extremes, corners, unknown kinds.
      csr_write(CSR_BUCKET_COUNT, CSR_DATA_WIDTH'(BUCKET_COUNT_RESET));
      csr_write(CSR_PHASE_SCALE, CSR_DATA_WIDTH'(PHASE_SCALE_RESET));
      send_fields(KIND_SIDE, 0, 0, 0, 0, 0, 0, 1'b1);
      send_fields(KIND_SIDE, 1, 0, 0, 0, 0, 0, 1'b0);
      send_fields(KIND_LOAD, 0, 10, -640, -100, 0, 0, 1'b0);
      send_fields(KIND_LOAD, 0, 10, -660, 200, 0, 0, 1'b0);
      send_fields(KIND_LOAD, 0, 10, -650, 32767, 0, 0, 1'b0);
      send_fields(KIND_LOAD, 0, 10, -700, -32768, 0, 0, 1'b0);
      send_fields(KIND_LOAD, 0, 10, -645, 5, 0, 0, 1'b0);       // bucket already full
      send_fields(KIND_LOAD, 7, 511, -32768, 0, 0, 0, 1'b0);
      send_fields(KIND_LOAD, 1, 360, -23040, 100, 0, 0, 1'b0);
      send_fields(KIND_POINT, 0, 0, -640, 0, 0, 0, 1'b0);
      send_fields(KIND_POINT, 0, 0, -640, 32767, 0, 0, 1'b0);
      send_fields(KIND_POINT, 0, 0, -640, -32768, 0, 0, 1'b0);
      send_fields(KIND_POINT, 0, 0, 640, 0, 0, 0, 1'b0);        // positive phase
      send_fields(KIND_POINT, 1, 0, -23040, 200, 0, 0, 1'b0);
      send_fields(KIND_BOX, 0, 0, -700, -50, -600, 50, 1'b0);   // infeasible
      send_fields(KIND_BOX, 0, 0, -700, 300, -600, 400, 1'b0);
      send_fields(KIND_BOX, 0, 0, -600, -50, -700, 50, 1'b0);   // inverted
      send_fields(KIND_BOX, 2, 0, -700, -50, -600, 50, 1'b0);   // nothing in span
      send_fields(KIND_BOX, 1, 0, -23040, -32768, 0, 32767, 1'b0);
      send_fields(KIND_BOX, 0, 0, -32768, -32768, 32767, 32767, 1'b0);
      send_fields(3'd5, 0, 0, -640, 0, 0, 0, 1'b1);
      send_fields(3'd6, 3, 0, 0, 0, 0, 0, 1'b0);
      send_fields(3'd7, 4, 0, 0, 0, 0, 0, 1'b1);
      send_fields(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 1'b0);
      send_fields(KIND_POINT, 0, 0, -640, 0, 0, 0, 1'b0);

      // Random phases, each under its own settings.
      for (phase_no = 0; phase_no < 5; phase_no++) begin
         drain();
         case (phase_no)
            0: ;
            1: begin
               csr_write(CSR_BUCKET_COUNT, CSR_DATA_WIDTH'(1));
               csr_write(CSR_PHASE_SCALE, 24'hffffff);
            end
            2: begin
               csr_write(CSR_BUCKET_COUNT, CSR_DATA_WIDTH'(511));
               csr_write(CSR_PHASE_SCALE, CSR_DATA_WIDTH'(0));
            end
            3: begin
               csr_write(CSR_BUCKET_COUNT, CSR_DATA_WIDTH'(511));
               csr_write(CSR_PHASE_SCALE, CSR_DATA_WIDTH'(93025));   // 512 buckets, full turn
            end
            default: begin
               csr_write(CSR_BUCKET_COUNT, CSR_DATA_WIDTH'(BUCKET_COUNT_RESET));
               csr_write(CSR_PHASE_SCALE, CSR_DATA_WIDTH'(PHASE_SCALE_RESET));
               quiet = 1'b1;
            end
         endcase
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (phase_no == 0 && i == 40) hold_rsp = 1'b1;   // back up the result side
            if (phase_no == 3 && i == 70) begin
               // pause the sender until every result is back
               req.valid <= 1'b0;
               @(posedge clock);
               while (pending != 0) @(posedge clock);
            end
            send(rand_beat());
         end
      end

      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("covered five settings with %0d box queries (%0d ambiguous)",
               box_count, ambiguous_count);
      $display("%0d loads rejected on full buckets, %0d mismatches", rejected_count, errors);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
